/* sv/assert_macros.svh */
// Assertion macros used by the top level RTL file of the letter prefix code encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition implies another in the same cycle, outside of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_SYNC(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* sv/lpce_pkg.sv */
// Types and constants of the letter prefix code encoder.
`timescale 1ns / 1ps

package lpce_pkg;

    localparam int LETTER_W    = 7;
    localparam int BYTE_W      = 8;
    localparam int BITS_USED_W = 20;
    localparam int CODE_W      = 6;
    localparam int LEN_W       = 3;
    localparam int IDX_W       = 4;
    localparam int PEND_W      = 7;
    localparam int CNT_W       = 3;
    localparam int ACC_W       = PEND_W + CODE_W;
    localparam int NBITS_W     = 4;

    // Queue depths; both are powers of two so the pointers wrap on their own.
    localparam int ITEM_DEPTH  = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int Q_PTR_W     = $clog2(ITEM_DEPTH);
    localparam int Q_CNT_W     = $clog2(ITEM_DEPTH + 1);
    localparam int OB_PTR_W    = $clog2(OUT_DEPTH);
    localparam int OB_CNT_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [Q_CNT_W-1:0]  Q_FULL       = Q_CNT_W'(ITEM_DEPTH);
    localparam logic [OB_CNT_W-1:0] OB_FULL      = OB_CNT_W'(OUT_DEPTH);
    localparam logic [OB_CNT_W-1:0] OB_POP_LIMIT = OB_CNT_W'(OUT_DEPTH - 2);

    // Letter offset classification.
    localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd97;
    localparam logic [LETTER_W-1:0] G0_LAST     = 7'd1;
    localparam logic [LETTER_W-1:0] G1_LAST     = 7'd5;
    localparam logic [LETTER_W-1:0] G2_LAST     = 7'd13;
    localparam logic [LETTER_W-1:0] G1_BASE     = 7'd2;
    localparam logic [LETTER_W-1:0] G2_BASE     = 7'd6;
    localparam logic [LETTER_W-1:0] G3_BASE     = 7'd14;
    localparam logic [LEN_W-1:0]    LEN_BASE    = 3'd3;
    localparam logic [NBITS_W-1:0]  BYTE_BITS   = 4'd8;

    typedef enum logic [1:0] {
        GRP_AB = 2'd0,
        GRP_CF = 2'd1,
        GRP_GN = 2'd2,
        GRP_OZ = 2'd3
    } t_group;

    // Classified letter: code bits LSB first, their count, end flag.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              eom;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0]      packed_byte;
        logic                   final_byte;
        logic [BITS_USED_W-1:0] bits_used;
    } t_res;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic [OB_CNT_W-1:0] ob_count;
        logic [CNT_W-1:0]    pend_count;
    } t_back_stat;

endpackage

/* sv/lpce_intf.sv */
// Valid/ready channel interfaces for letters in and packed bytes out.
`timescale 1ns / 1ps

interface lpce_in_if;
    logic                          valid;
    logic                          ready;
    logic [lpce_pkg::LETTER_W-1:0] letter;
    logic                          end_of_message;

    modport source (output valid, output letter, output end_of_message, input ready);
    modport sink   (input valid, input letter, input end_of_message, output ready);
endinterface

interface lpce_out_if;
    logic                             valid;
    logic                             ready;
    logic [lpce_pkg::BYTE_W-1:0]      packed_byte;
    logic                             final_byte;
    logic [lpce_pkg::BITS_USED_W-1:0] bits_used;

    modport source (output valid, output packed_byte, output final_byte, output bits_used,
                    input ready);
    modport sink   (input valid, input packed_byte, input final_byte, input bits_used,
                    output ready);
endinterface

/* sv/letter_prefix_code_encoder.sv */
// A letter passes through the registered item queue and the registered output buffer.
// Throughput: one letter per cycle when the queue has room; up to one byte per cycle.
// The back end takes a letter when two output buffer slots are free.
// Reset (synchronous, active low) empties both queues and clears pending bits and count.
// Top level: letter prefix code encoder, front end, item queue and packing back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module letter_prefix_code_encoder #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpce_in_if.sink     i_in,
    lpce_out_if.source  o_out
);

    logic                  w_push;
    logic                  w_q_ready;
    logic                  w_q_valid;
    logic                  w_pop;
    lpce_pkg::t_item       w_front_item;
    lpce_pkg::t_item       w_q_item;
    lpce_pkg::t_q_stat     w_q_stat;
    lpce_pkg::t_back_stat  w_back_stat;

    lpce_front u_front (
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    lpce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat)
    );

    lpce_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_out   (o_out),
        .o_stat  (w_back_stat)
    );

    // Output buffer never overfills.
    `ASSERT_SYNC(a_ob_bound, i_clk, i_rst_n, w_back_stat.ob_count <= lpce_pkg::OB_FULL, "output buffer overflow")
    // Non-final bytes report no bit count.
    `ASSERT_IMPLY(a_count_final, i_clk, i_rst_n, o_out.valid && !o_out.final_byte, o_out.bits_used == '0, "bit count on non-final byte")
    // Input stalls only when the item queue is full.
    `ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, !i_in.ready, w_q_stat.count == lpce_pkg::Q_FULL, "input stalled with queue room")

endmodule

/* sv/lpce_front.sv */
// Front end: accept letters and classify them into prefix code words.
`timescale 1ns / 1ps

module lpce_front (
    lpce_in_if.sink                 i_in,
    input  logic                    i_q_ready,
    output logic                    o_push,
    output lpce_pkg::t_item         o_item
);

    logic [lpce_pkg::LETTER_W-1:0] w_offset;
    logic [lpce_pkg::LETTER_W-1:0] w_index_full;
    lpce_pkg::t_group              w_group;

    // Accept whenever the queue has room.
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid & i_q_ready;

    // Classify the letter offset into group and index.
    always_comb begin
        w_offset = i_in.letter - lpce_pkg::LETTER_BASE;
        priority if (w_offset <= lpce_pkg::G0_LAST) begin
            w_group      = lpce_pkg::GRP_AB;
            w_index_full = w_offset;
        end else if (w_offset <= lpce_pkg::G1_LAST) begin
            w_group      = lpce_pkg::GRP_CF;
            w_index_full = w_offset - lpce_pkg::G1_BASE;
        end else if (w_offset <= lpce_pkg::G2_LAST) begin
            w_group      = lpce_pkg::GRP_GN;
            w_index_full = w_offset - lpce_pkg::G2_BASE;
        end else begin
            w_group      = lpce_pkg::GRP_OZ;
            w_index_full = w_offset - lpce_pkg::G3_BASE;
        end
    end

    // Build the code word: group first, then index; index never exceeds its length.
    always_comb begin
        o_item.code = {w_index_full[lpce_pkg::IDX_W-1:0], w_group};
        o_item.len  = {1'b0, w_group} + lpce_pkg::LEN_BASE;
        o_item.eom  = i_in.end_of_message;
    end

endmodule

/* sv/lpce_fifo.sv */
// Short queue of classified letters between the front and back ends.
`timescale 1ns / 1ps

module lpce_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpce_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_valid,
    output lpce_pkg::t_item   o_item,
    input  logic              i_pop,
    output lpce_pkg::t_q_stat o_stat
);

    lpce_pkg::t_item               r_mem [lpce_pkg::ITEM_DEPTH];
    logic [lpce_pkg::Q_PTR_W-1:0]  r_wp;
    logic [lpce_pkg::Q_PTR_W-1:0]  r_rp;
    logic [lpce_pkg::Q_CNT_W-1:0]  r_cnt;
    logic [lpce_pkg::Q_CNT_W-1:0]  n_cnt;
    logic                          w_wr;
    logic                          w_rd;

    assign o_ready      = (r_cnt != lpce_pkg::Q_FULL);
    assign o_valid      = (r_cnt != '0);
    assign o_item       = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign w_wr         = i_push & o_ready;
    assign w_rd         = i_pop & o_valid;

    // Track fill level.
    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Store the transaction payload.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* sv/lpce_back.sv */
// Back end: pack code bits into bytes, count bits, buffer the output bytes.
`timescale 1ns / 1ps

module lpce_back #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  lpce_pkg::t_item      i_item,
    output logic                 o_pop,
    lpce_out_if.source           o_out,
    output lpce_pkg::t_back_stat o_stat
);

    localparam int EXT_W = COUNT_WIDTH + lpce_pkg::BITS_USED_W;

    // Packing state
    logic [lpce_pkg::PEND_W-1:0]   r_pend;
    logic [lpce_pkg::CNT_W-1:0]    r_pcnt;
    logic [COUNT_WIDTH-1:0]        r_total;

    // Output buffer
    lpce_pkg::t_res                r_ob [lpce_pkg::OUT_DEPTH];
    logic [lpce_pkg::OB_PTR_W-1:0] r_wp;
    logic [lpce_pkg::OB_PTR_W-1:0] r_rp;
    logic [lpce_pkg::OB_CNT_W-1:0] r_cnt;

    logic [lpce_pkg::ACC_W-1:0]    w_acc;
    logic [lpce_pkg::NBITS_W-1:0]  w_n;
    logic [lpce_pkg::NBITS_W-1:0]  w_rem;
    logic [lpce_pkg::BYTE_W-1:0]   w_rem_bits;
    logic                          w_hi;
    logic                          w_b_valid;
    logic [COUNT_WIDTH:0]          w_sum;
    logic [COUNT_WIDTH-1:0]        w_total;
    logic [EXT_W-1:0]              w_ext;
    logic [lpce_pkg::BITS_USED_W-1:0] w_bits;
    lpce_pkg::t_res                w_res_a;
    lpce_pkg::t_res                w_res_b;
    lpce_pkg::t_res                w_wr0;
    logic [1:0]                    w_wr_num;
    logic                          w_out_take;
    logic [lpce_pkg::OB_CNT_W-1:0] n_cnt;

    // Take an item only when two result slots are free.
    assign o_pop      = i_valid && (r_cnt <= lpce_pkg::OB_POP_LIMIT);
    assign w_out_take = o_out.valid & o_out.ready;

    // Saturating bit count.
    always_comb begin
        w_sum   = {1'b0, r_total} + (COUNT_WIDTH + 1)'(i_item.len);
        w_total = w_sum[COUNT_WIDTH] ? '1 : w_sum[COUNT_WIDTH-1:0];
        w_ext   = {{lpce_pkg::BITS_USED_W{1'b0}}, w_total};
        w_bits  = w_ext[lpce_pkg::BITS_USED_W-1:0];
    end

    // Append code bits to the pending bits and split off a full byte.
    always_comb begin
        w_acc = {{lpce_pkg::CODE_W{1'b0}}, r_pend}
              | ({{lpce_pkg::PEND_W{1'b0}}, i_item.code} << r_pcnt);
        w_n   = {1'b0, r_pcnt} + {1'b0, i_item.len};
        w_hi  = (w_n >= lpce_pkg::BYTE_BITS);
        if (w_hi) begin
            w_rem      = w_n - lpce_pkg::BYTE_BITS;
            w_rem_bits = {{(2 * lpce_pkg::BYTE_W - lpce_pkg::ACC_W){1'b0}},
                          w_acc[lpce_pkg::ACC_W-1:lpce_pkg::BYTE_W]};
        end else begin
            w_rem      = w_n;
            w_rem_bits = w_acc[lpce_pkg::BYTE_W-1:0];
        end
        w_b_valid = i_item.eom && (w_rem != '0);
    end

    // Form the full-byte result and the flushed partial byte.
    always_comb begin
        w_res_a.packed_byte = w_acc[lpce_pkg::BYTE_W-1:0];
        w_res_a.final_byte  = i_item.eom && (w_n == lpce_pkg::BYTE_BITS);
        w_res_a.bits_used   = w_res_a.final_byte ? w_bits : '0;
        w_res_b.packed_byte = w_rem_bits;
        w_res_b.final_byte  = 1'b1;
        w_res_b.bits_used   = w_bits;
        w_wr0               = w_hi ? w_res_a : w_res_b;
        w_wr_num            = o_pop ? ({1'b0, w_hi} + {1'b0, w_b_valid}) : 2'd0;
    end

    // Output buffer fill level.
    always_comb begin
        n_cnt = r_cnt + lpce_pkg::OB_CNT_W'(w_wr_num) - lpce_pkg::OB_CNT_W'(w_out_take);
    end

    // Update packing state and buffer pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_pcnt  <= '0;
            r_total <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_wp  <= r_wp + lpce_pkg::OB_PTR_W'(w_wr_num);
            if (w_out_take) begin
                r_rp <= r_rp + 1'b1;
            end
            if (o_pop) begin
                if (i_item.eom) begin
                    r_pend  <= '0;
                    r_pcnt  <= '0;
                    r_total <= '0;
                end else begin
                    r_pend  <= w_rem_bits[lpce_pkg::PEND_W-1:0];
                    r_pcnt  <= w_rem[lpce_pkg::CNT_W-1:0];
                    r_total <= w_total;
                end
            end
        end
    end

    // Write up to two results per item.
    always_ff @(posedge i_clk) begin
        if (w_wr_num != 2'd0) begin
            r_ob[r_wp] <= w_wr0;
        end
        if (w_wr_num == 2'd2) begin
            r_ob[r_wp + 1'b1] <= w_res_b;
        end
    end

    // Drive the output transaction from the buffer head.
    always_comb begin
        o_out.valid       = (r_cnt != '0);
        o_out.packed_byte = r_ob[r_rp].packed_byte;
        o_out.final_byte  = r_ob[r_rp].final_byte;
        o_out.bits_used   = r_ob[r_rp].bits_used;
    end

    assign o_stat.ob_count   = r_cnt;
    assign o_stat.pend_count = r_pcnt;

endmodule

/* tb/sv/letter_prefix_code_encoder_test.sv */
// Self-checking testbench for the letter prefix code encoder with random handshake idling.
`timescale 1ns / 1ps

module letter_prefix_code_encoder_test;

    import lpce_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 780;
    localparam int CALM_ITEMS    = 100;
    localparam int PRESSURE_AT   = 150;
    localparam int PRESSURE_HOLD = 400;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                eom;
    } letter_txn_t;

    logic i_clk;
    logic i_rst_n;

    lpce_in_if  letters_if ();
    lpce_out_if bytes_if ();

    letter_prefix_code_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (letters_if),
        .o_out   (bytes_if)
    );

    // Encoder state as predicted from the accepted letters
    logic [PEND_W-1:0]      held_bits;
    logic [CNT_W-1:0]       held_count;
    logic [BITS_USED_W-1:0] message_bits;

    letter_txn_t letter_queue[$];
    t_res        expected_bytes[$];

    int  letters_queued;
    int  letters_taken;
    int  stall_cycles;
    int  error_count;
    int  src_gap;
    int  sink_hold;
    bit  in_taken;
    bit  calm;
    bit  pressure_done;

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Encode one letter and queue the bytes it completes
    function automatic void encode_letter(input logic [LETTER_W-1:0] letter, input logic eom);
        logic [LETTER_W-1:0]  offset;
        t_group               group;
        logic [IDX_W-1:0]     index;
        logic [LEN_W-1:0]     len;
        logic [CODE_W-1:0]    code;
        logic [ACC_W-1:0]     acc;
        logic [NBITS_W-1:0]   nbits;
        logic [BITS_USED_W:0] sum;
        t_res                 res;
        offset = letter - LETTER_BASE;
        if (offset <= G0_LAST) begin
            group = GRP_AB;
            index = IDX_W'(offset);
        end else if (offset <= G1_LAST) begin
            group = GRP_CF;
            index = IDX_W'(offset - G1_BASE);
        end else if (offset <= G2_LAST) begin
            group = GRP_GN;
            index = IDX_W'(offset - G2_BASE);
        end else begin
            group = GRP_OZ;
            index = IDX_W'(offset - G3_BASE);
        end
        len  = LEN_BASE + LEN_W'(group);
        code = CODE_W'({index, 2'(group)}) & CODE_W'((1 << len) - 1);

        // Saturate the message bit count
        sum = {1'b0, message_bits} + (BITS_USED_W + 1)'(len);
        message_bits = sum[BITS_USED_W] ? '1 : sum[BITS_USED_W-1:0];

        acc   = ACC_W'(held_bits) | (ACC_W'(code) << held_count);
        nbits = NBITS_W'(held_count) + NBITS_W'(len);

        // Emit a full byte
        if (nbits >= BYTE_BITS) begin
            res.packed_byte = acc[BYTE_W-1:0];
            res.final_byte  = eom && (nbits == BYTE_BITS);
            res.bits_used   = res.final_byte ? message_bits : '0;
            expected_bytes.push_back(res);
            acc   = acc >> BYTE_W;
            nbits = nbits - BYTE_BITS;
        end
        // Flush the partial byte with zero fill
        if (eom && nbits != 0) begin
            res.packed_byte = acc[BYTE_W-1:0] & BYTE_W'((1 << nbits) - 1);
            res.final_byte  = 1'b1;
            res.bits_used   = message_bits;
            expected_bytes.push_back(res);
            nbits = '0;
        end

        if (eom) begin
            held_bits    = '0;
            held_count   = '0;
            message_bits = '0;
        end else begin
            held_bits  = acc[PEND_W-1:0];
            held_count = nbits[CNT_W-1:0];
        end
    endfunction

    task automatic queue_letter(input logic [LETTER_W-1:0] letter, input logic eom);
        letter_txn_t txn;
        txn.letter = letter;
        txn.eom    = eom;
        letter_queue.push_back(txn);
        letters_queued++;
    endtask

    // Queue random messages, mostly short, letters mostly in range
    task automatic queue_messages(input int n_items);
        int len;
        int k;
        k = 0;
        while (k < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                queue_letter(($urandom_range(0, 9) == 0) ? LETTER_W'($urandom_range(0, 127))
                                                         : LETTER_W'($urandom_range(97, 122)),
                             i == len - 1);
            end
            k += len;
        end
    endtask

    // Wait until every letter is taken and every byte has arrived, or until the stall limit is hit
    task automatic wait_drained(output bit timed_out);
        timed_out = 1'b0;
        while (letters_taken != letters_queued || expected_bytes.size() != 0) begin
            @(negedge i_clk);
            if (stall_cycles >= STALL_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end
    endtask

    // Letter driver: hold each transaction until taken, insert random gaps
    always @(negedge i_clk) begin : letter_driver
        letter_txn_t txn;
        if (!i_rst_n) begin
            letters_if.valid <= 1'b0;
        end else if (!letters_if.valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                letters_if.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(1, 13) - 1;
                letters_if.valid <= 1'b0;
            end else if (letter_queue.size() > 0) begin
                txn = letter_queue.pop_front();
                letters_if.valid          <= 1'b1;
                letters_if.letter         <= txn.letter;
                letters_if.end_of_message <= txn.eom;
            end else begin
                letters_if.valid <= 1'b0;
            end
        end
    end

    // Byte sink: random stalls and one long hold-off to back up the encoder
    always @(negedge i_clk) begin : byte_sink
        if (!i_rst_n) begin
            bytes_if.ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            bytes_if.ready <= 1'b0;
        end else if (!pressure_done && letters_taken >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            sink_hold     = PRESSURE_HOLD - 1;
            bytes_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(1, 13) - 1;
            bytes_if.ready <= 1'b0;
        end else begin
            bytes_if.ready <= 1'b1;
        end
    end

    // Monitor: check bytes against the predicted ones, predict from taken letters
    always @(posedge i_clk) begin : monitor
        t_res exp_res;
        bit   out_fire;
        if (i_rst_n) begin
            in_taken = letters_if.valid && letters_if.ready;
            out_fire = bytes_if.valid && bytes_if.ready;
            if (out_fire) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual %h",
                             $time, bytes_if.packed_byte);
                    error_count++;
                end else begin
                    exp_res = expected_bytes.pop_front();
                    if (bytes_if.packed_byte !== exp_res.packed_byte) begin
                        $display("%0t: packed_byte expected %h actual %h",
                                 $time, exp_res.packed_byte, bytes_if.packed_byte);
                        error_count++;
                    end
                    if (bytes_if.final_byte !== exp_res.final_byte) begin
                        $display("%0t: final_byte expected %b actual %b",
                                 $time, exp_res.final_byte, bytes_if.final_byte);
                        error_count++;
                    end
                    if (bytes_if.bits_used !== exp_res.bits_used) begin
                        $display("%0t: bits_used expected %0d actual %0d",
                                 $time, exp_res.bits_used, bytes_if.bits_used);
                        error_count++;
                    end
                end
            end
            if (in_taken) begin
                encode_letter(letters_if.letter, letters_if.end_of_message);
                letters_taken++;
            end
            stall_cycles = (in_taken || out_fire) ? 0 : stall_cycles + 1;
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        bit timed_out;
        i_rst_n                   = 1'b0;
        letters_if.valid          = 1'b0;
        letters_if.letter         = '0;
        letters_if.end_of_message = 1'b0;
        bytes_if.ready            = 1'b0;
        held_bits                 = '0;
        held_count                = '0;
        message_bits              = '0;
        letters_queued            = 0;
        letters_taken             = 0;
        stall_cycles              = 0;
        error_count               = 0;
        src_gap                   = 0;
        sink_hold                 = 0;
        in_taken                  = 1'b0;
        calm                      = 1'b0;
        pressure_done             = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single short letter, flushed as a partial byte
        queue_letter(LETTER_W'("a"), 1'b1);
        // Group boundaries
        queue_letter(LETTER_W'("b"), 1'b0);
        queue_letter(LETTER_W'("c"), 1'b0);
        queue_letter(LETTER_W'("f"), 1'b0);
        queue_letter(LETTER_W'("g"), 1'b0);
        queue_letter(LETTER_W'("n"), 1'b0);
        queue_letter(LETTER_W'("o"), 1'b0);
        queue_letter(LETTER_W'("z"), 1'b1);
        // Exactly eight bits at the end: final flag on the full byte
        queue_letter(LETTER_W'("c"), 1'b0);
        queue_letter(LETTER_W'("d"), 1'b1);
        // Twelve bits at the end: full byte then flushed partial byte
        queue_letter(LETTER_W'("z"), 1'b0);
        queue_letter(LETTER_W'("z"), 1'b1);
        // Letters outside a..z land in the o..z group; those below a wrap the offset
        queue_letter(7'd0, 1'b0);
        queue_letter(7'd127, 1'b0);
        queue_letter(7'd96, 1'b0);
        queue_letter(7'd123, 1'b0);
        queue_letter(7'd64, 1'b1);
        queue_letter(LETTER_W'("m"), 1'b0);
        queue_letter(LETTER_W'("y"), 1'b0);
        queue_letter(LETTER_W'("e"), 1'b1);

        queue_messages(RANDOM_ITEMS);
        wait_drained(timed_out);

        // Quiet tail: no idling on either side, count restarts per message
        if (!timed_out) begin
            calm <= 1'b1;
            queue_letter(LETTER_W'("h"), 1'b0);
            queue_letter(LETTER_W'("k"), 1'b1);
            queue_messages(CALM_ITEMS);
            wait_drained(timed_out);
        end

        if (timed_out) begin
            $display("Verification failed");
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            if (error_count == 0 && expected_bytes.size() == 0) begin
                $display("Verification passed");
            end else begin
                $display("Verification failed");
            end
        end
        $finish;
    end

endmodule

/* letter_prefix_code_encoder.f */
+incdir+sv
sv/lpce_pkg.sv
sv/lpce_intf.sv
sv/lpce_front.sv
sv/lpce_fifo.sv
sv/lpce_back.sv
sv/letter_prefix_code_encoder.sv
tb/sv/letter_prefix_code_encoder_test.sv
